@@ rtl/pss_pkg.sv @@
package pss_pkg;

  localparam int STAGES_DEF     = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int FIELD_W        = 16;

  localparam logic [1:0] KIND_PRIME    = 2'd0;
  localparam logic [1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [1:0] KIND_DONE     = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] candidate;
    logic               end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] found_value;
    logic [1:0]         kind;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic is_zero;
  } rem_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_RESULT
  } state_t;

endpackage

@@ rtl/pipeline_prime_sieve_unit.sv @@
// Prime sieve: a chain of up to STAGES stored divisors held in one RAM.
// Input channel (in_valid/in_ready/in_data) carries a candidate or an
// end-of-stream marker; result channel (out_valid/out_ready/out_data)
// carries a new prime (kind 0), an overflow drop (kind 1) or done (kind 2).
// A candidate divisible by any stored value gives no result.
// Timing: one item at a time. Each stored divisor takes a RAM read, a
// load and a serial remainder at one bit per cycle, so the serial
// remainder unit dominates the time per item. End of stream goes from
// the input step straight to the result step.
// Results sit in an output register; a new item is accepted while a
// result waits. If the receiver stalls, the next result holds until the
// register frees, and input is not taken meanwhile.
// Reset (rst_n low, synchronous) empties the chain; RAM contents need no
// clearing, only entries below the fill count are ever read.
module pipeline_prime_sieve_unit
  import pss_pkg::*;
#(
  parameter int STAGES     = STAGES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int CNT_W = $clog2(STAGES + 1);

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  logic                  rem_start;
  logic [VALUE_BITS-1:0] rem_num;
  rem_stat_t             rem_stat;

  pss_ctrl #(
    .STAGES     (STAGES),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .rem_start (rem_start),
    .rem_num   (rem_num),
    .rem_stat  (rem_stat)
  );

  pss_mem #(
    .DEPTH (STAGES),
    .WIDTH (VALUE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pss_rem #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .num   (rem_num),
    .den   (mem_rdata),
    .stat  (rem_stat)
  );

endmodule

@@ rtl/pss_mem.sv @@
module pss_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pss_rem.sv @@
module pss_rem
  import pss_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] num,
  input  logic [VALUE_BITS-1:0] den,
  output rem_stat_t             stat
);

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [VALUE_BITS-1:0] den_r, den_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;

  // restoring division, one quotient bit per cycle; den of zero leaves num
  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, num_r[VALUE_BITS-1]};
    diff     = shifted - {1'b0, den_r};
    if (start) begin
      rem_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      step_nxt = STEP_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[VALUE_BITS-1:0];
      end else begin
        rem_nxt = shifted[VALUE_BITS-1:0];
      end
      num_nxt  = num_r << 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign stat.done    = done_r;
  assign stat.is_zero = (rem_r == '0);

endmodule

@@ rtl/pss_ctrl.sv @@
module pss_ctrl
  import pss_pkg::*;
#(
  parameter int STAGES     = STAGES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output logic [VALUE_BITS-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [IDX_W-1:0]      mem_raddr,
  output logic                  rem_start,
  output logic [VALUE_BITS-1:0] rem_num,
  input  rem_stat_t             rem_stat
);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic                  eos_r, eos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    cand_nxt      = cand_r;
    eos_nxt       = eos_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    rem_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cand_nxt = VALUE_BITS'(in_data.candidate);
          eos_nxt  = in_data.end_of_stream;
          idx_nxt  = '0;
          if (in_data.end_of_stream || count_r == '0) begin
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        rem_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.is_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            if (idx_r + CNT_W'(1) == count_r) begin
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (eos_r) begin
            count_nxt                = '0;
            out_data_nxt.found_value = '0;
            out_data_nxt.kind        = KIND_DONE;
          end else if (count_r == CNT_W'(STAGES)) begin
            out_data_nxt.found_value = FIELD_W'(cand_r);
            out_data_nxt.kind        = KIND_OVERFLOW;
          end else begin
            mem_we                   = 1'b1;
            count_nxt                = count_r + CNT_W'(1);
            out_data_nxt.found_value = FIELD_W'(cand_r);
            out_data_nxt.kind        = KIND_PRIME;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    eos_r      <= eos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign mem_waddr = count_r[IDX_W-1:0];
  assign mem_wdata = cand_r;
  assign mem_raddr = idx_r[IDX_W-1:0];
  assign rem_num   = cand_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
